>>> design/fw2d_pkg.sv
// ============================================================================
// fw2d_pkg: shared constants and types for the 2-D Fenwick rectangle-sum block
// Grid size, derived index widths, stream field layout, and the command and
// status bundles passed between the controller and the datapath.
// ============================================================================
package fw2d_pkg;

  // Grid size
  localparam int ROWS  = 64;
  localparam int COLS  = 64;
  localparam int DEPTH = ROWS * COLS;

  // Cell address width and walk index widths (an add walk may step past the
  // grid edge by up to the grid size, so one extra bit is kept)
  localparam int AW  = $clog2(DEPTH);
  localparam int RIW = $clog2(2 * ROWS + 1);
  localparam int CIW = $clog2(2 * COLS + 1);

  // Stream field widths
  localparam int CW      = 7;
  localparam int DW      = 32;
  localparam int IN_BITS = 4 * CW + DW;
  localparam int IN_TW   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TW  = DW;

  // Operation selected by tuser
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture an input item
    logic clr_step;    // zero one cell of the clearing sweep
    logic walk_init;   // start the prefix walk of the current corner
    logic corner_inc;  // move on to the next corner
    logic q_step;      // read one cell of a prefix walk and step downward
    logic add_rd;      // read the cell under the add walk
    logic add_wr;      // write back cell plus delta and step upward
    logic out_load;    // move the finished sum to the output register
  } fw2d_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;    // clearing sweep is at its last cell
    logic func;        // operation of the captured item
    logic add_ok;      // captured add point lies inside the grid
    logic walk_empty;  // current prefix is empty
    logic q_last;      // this prefix read is the last of its chain
    logic corner_last; // current corner is the fourth
    logic add_last;    // this add write is the last of the chain
    logic out_busy;    // output register cannot take a new sum this cycle
  } fw2d_sts_t;

endpackage

>>> design/fw2d_dp.sv
// ============================================================================
// fw2d_dp: datapath of the 2-D Fenwick rectangle-sum block
// Holds the tree memory, the captured coordinates, the row and column walk
// indices, the signed accumulator and the output register.
// ============================================================================
module fw2d_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fw2d_pkg::fw2d_cmd_t          cmd_i,
  output fw2d_pkg::fw2d_sts_t          sts_o,
  input  logic [fw2d_pkg::IN_TW-1:0]   in_tdata_i,
  input  logic                         in_tuser_i,
  input  logic                         out_tready_i,
  output logic                         out_tvalid_o,
  output logic [fw2d_pkg::OUT_TW-1:0]  out_tdata_o
);

  localparam int AW  = fw2d_pkg::AW;
  localparam int RIW = fw2d_pkg::RIW;
  localparam int CIW = fw2d_pkg::CIW;
  localparam int CW  = fw2d_pkg::CW;
  localparam int DW  = fw2d_pkg::DW;

  // Row coordinate saturated to the grid
  function automatic logic [RIW-1:0] sat_row(input logic [CW-1:0] v);
    logic [RIW-1:0] r;
    r = (32'(v) > 32'(fw2d_pkg::ROWS)) ? RIW'(fw2d_pkg::ROWS) : RIW'(v);
    return r;
  endfunction

  // Column coordinate saturated to the grid
  function automatic logic [CIW-1:0] sat_col(input logic [CW-1:0] v);
    logic [CIW-1:0] c;
    c = (32'(v) > 32'(fw2d_pkg::COLS)) ? CIW'(fw2d_pkg::COLS) : CIW'(v);
    return c;
  endfunction

  // Unpack the input fields
  logic [CW-1:0] x1, y1, x2, y2;
  logic [DW-1:0] delta;
  assign x1    = in_tdata_i[CW-1:0];
  assign y1    = in_tdata_i[2*CW-1:CW];
  assign x2    = in_tdata_i[3*CW-1:2*CW];
  assign y2    = in_tdata_i[4*CW-1:3*CW];
  assign delta = in_tdata_i[4*CW+DW-1:4*CW];

  // Captured item
  logic           func_q, add_ok_q;
  logic [DW-1:0]  delta_q;
  logic [RIW-1:0] rhi_q, rlo_q;
  logic [CIW-1:0] chi_q, clo_q;

  // Walk state
  logic [RIW-1:0] i_q;
  logic [CIW-1:0] j_q;
  logic [1:0]     corner_q;
  logic [AW-1:0]  clr_q;

  // Read pipe and accumulator
  logic           rd_vld_q, rd_neg_q;
  logic [DW-1:0]  rdata_q, acc_q;

  // Output register
  logic           out_vld_q;
  logic [DW-1:0]  out_data_q;

  // Tree memory
  logic [DW-1:0]  mem [fw2d_pkg::DEPTH];

  // Corner of the inclusion-exclusion: bit 0 picks the low row, bit 1 the low column
  logic [RIW-1:0] corner_row;
  logic [CIW-1:0] corner_col;
  assign corner_row = corner_q[0] ? rlo_q : rhi_q;
  assign corner_col = corner_q[1] ? clo_q : chi_q;

  // Lowbit steps in both directions
  logic [RIW-1:0] lb_i, i_dn, i_up;
  logic [CIW-1:0] lb_j, j_dn, j_up;
  logic           j_wrap;
  assign lb_i   = i_q & (~i_q + RIW'(1));
  assign lb_j   = j_q & (~j_q + CIW'(1));
  assign i_dn   = i_q - lb_i;
  assign j_dn   = j_q - lb_j;
  assign i_up   = i_q + lb_i;
  assign j_up   = j_q + lb_j;
  assign j_wrap = 32'(j_up) > 32'(fw2d_pkg::COLS);

  // Cell address (i-1)*COLS + (j-1)
  logic [AW-1:0] cell_addr, wr_addr;
  logic [DW-1:0] wr_data;
  logic          wr_en;
  assign cell_addr = AW'(AW'(i_q - RIW'(1)) * AW'(fw2d_pkg::COLS))
                   + AW'(j_q - CIW'(1));
  assign wr_en     = cmd_i.clr_step | cmd_i.add_wr;
  assign wr_addr   = cmd_i.clr_step ? clr_q : cell_addr;
  assign wr_data   = cmd_i.clr_step ? '0 : (rdata_q + delta_q);

  // Memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_step || cmd_i.add_rd) begin
      rdata_q <= mem[cell_addr];
    end
  end

  // Captured item and walk indices
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= in_tuser_i;
      delta_q  <= delta;
      add_ok_q <= (x1 != '0) && (32'(x1) <= 32'(fw2d_pkg::ROWS))
                && (y1 != '0) && (32'(y1) <= 32'(fw2d_pkg::COLS));
      if (in_tuser_i == fw2d_pkg::FUNC_QUERY) begin
        rhi_q <= sat_row(x2);
        chi_q <= sat_col(y2);
        rlo_q <= (x1 == '0) ? '0 : sat_row(x1 - CW'(1));
        clo_q <= (y1 == '0) ? '0 : sat_col(y1 - CW'(1));
      end else begin
        // add walk starts at the point; chi_q keeps the start column
        rhi_q <= sat_row(x1);
        chi_q <= sat_col(y1);
        rlo_q <= '0;
        clo_q <= '0;
        i_q   <= sat_row(x1);
        j_q   <= sat_col(y1);
      end
    end else if (cmd_i.walk_init) begin
      i_q <= corner_row;
      j_q <= corner_col;
    end else if (cmd_i.q_step) begin
      if (j_dn == '0) begin
        i_q <= i_dn;
        j_q <= corner_col;
      end else begin
        j_q <= j_dn;
      end
    end else if (cmd_i.add_wr) begin
      if (j_wrap) begin
        i_q <= i_up;
        j_q <= chi_q;
      end else begin
        j_q <= j_up;
      end
    end
  end

  // Accumulator: clears on capture, takes each read as it returns
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      acc_q <= rd_neg_q ? (acc_q - rdata_q) : (acc_q + rdata_q);
    end
  end

  // Control registers: corner, clearing sweep, read pipe, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q  <= '0;
      clr_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_neg_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        corner_q <= '0;
      end else if (cmd_i.corner_inc) begin
        corner_q <= corner_q + 2'd1;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      rd_vld_q <= cmd_i.q_step;
      rd_neg_q <= corner_q[0] ^ corner_q[1];
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output data
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= acc_q;
    end
  end

  assign out_tvalid_o = out_vld_q;
  assign out_tdata_o  = out_data_q;

  // Status back to the controller
  always_comb begin
    sts_o.clr_done    = (clr_q == AW'(fw2d_pkg::DEPTH - 1));
    sts_o.func        = func_q;
    sts_o.add_ok      = add_ok_q;
    sts_o.walk_empty  = (i_q == '0) || (j_q == '0);
    sts_o.q_last      = (j_dn == '0) && (i_dn == '0);
    sts_o.corner_last = (corner_q == 2'd3);
    sts_o.add_last    = j_wrap && (32'(i_up) > 32'(fw2d_pkg::ROWS));
    sts_o.out_busy    = out_vld_q && !out_tready_i;
  end

endmodule

>>> design/fw2d_ctrl.sv
// ============================================================================
// fw2d_ctrl: controller of the 2-D Fenwick rectangle-sum block
// Sequences the clearing sweep, the read-modify-write add walk and the four
// prefix walks of a query, and hands the sum to the output register.
// ============================================================================
module fw2d_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_tvalid_i,
  output logic                 in_tready_o,
  input  fw2d_pkg::fw2d_sts_t  sts_i,
  output fw2d_pkg::fw2d_cmd_t  cmd_o
);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_DISP    = 4'd2;
  localparam logic [3:0] ST_A_RD    = 4'd3;
  localparam logic [3:0] ST_A_WR    = 4'd4;
  localparam logic [3:0] ST_Q_INIT  = 4'd5;
  localparam logic [3:0] ST_Q_WALK  = 4'd6;
  localparam logic [3:0] ST_Q_DRAIN = 4'd7;
  localparam logic [3:0] ST_Q_OUT   = 4'd8;

  logic [3:0] state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_tready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    logic corner_end;
    corner_end = 1'b0;
    state_d    = state_q;
    cmd_o      = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        if (sts_i.func == fw2d_pkg::FUNC_QUERY) begin
          state_d = ST_Q_INIT;
        end else if (sts_i.add_ok) begin
          state_d = ST_A_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_A_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = ST_A_WR;
      end
      ST_A_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = sts_i.add_last ? ST_IDLE : ST_A_RD;
      end
      ST_Q_INIT: begin
        cmd_o.walk_init = 1'b1;
        state_d         = ST_Q_WALK;
      end
      ST_Q_WALK: begin
        if (sts_i.walk_empty) begin
          corner_end = 1'b1;
        end else begin
          cmd_o.q_step = 1'b1;
          corner_end   = sts_i.q_last;
        end
        // four corners, then let the last read settle
        if (corner_end) begin
          if (sts_i.corner_last) begin
            state_d = ST_Q_DRAIN;
          end else begin
            cmd_o.corner_inc = 1'b1;
            state_d          = ST_Q_INIT;
          end
        end
      end
      ST_Q_DRAIN: begin
        state_d = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/fenwick_tree_2d_rect_sum.sv
// ============================================================================
// fenwick_tree_2d_rect_sum: rectangle sums over a 2-D binary indexed tree
// Point adds and inclusive rectangle queries over a ROWS by COLS grid of
// 32-bit wrapping cells.
// ============================================================================
//
//   channel  dir  handshake                   payload
//   s_axis   in   s_axis_tvalid/s_axis_tready tdata: x1,y1,x2,y2,delta; tuser: func
//   m_axis   out  m_axis_tvalid/m_axis_tready tdata: rect_sum
//
// After reset a clearing sweep zeroes the tree, one cell per cycle, before the first
// transfer is taken. One item is worked on at a time.
// Add: a read and a write-back of each touched cell, up to 7*7 cells at 64 by 64.
// Query: one read per cycle over four prefix chains, each corner opened by a walk
// init step; the sum then waits in an output register, so a stalled m_axis only
// holds the next query at its end.
// ----------------------------------------------------------------------------
module fenwick_tree_2d_rect_sum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [6:0] x1, [13:7] y1, [20:14] x2, [27:21] y2, [59:28] delta, [63:60] zero
  input  logic [fw2d_pkg::IN_TW-1:0]   s_axis_tdata,
  // [0] func
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [31:0] rect_sum
  output logic [fw2d_pkg::OUT_TW-1:0]  m_axis_tdata
);

  fw2d_pkg::fw2d_cmd_t cmd;
  fw2d_pkg::fw2d_sts_t sts;

  // Sequencer
  fw2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Tree memory, walk indices and accumulator
  fw2d_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata)
  );

endmodule

>>> tb/sv/fenwick_tree_2d_rect_sum_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// fenwick_tree_2d_rect_sum_tb: self-checking bench for the 2-D rectangle-sum
// Point adds and rectangle queries go through s_axis. A local copy of the
// binary indexed tree predicts every query sum when its transfer is taken,
// and m_axis sums are checked in order. Both sides idle at random, and at
// one point the result side holds off long enough to back up the input.
// ============================================================================
module fenwick_tree_2d_rect_sum_tb;

  localparam int HALF_PERIOD    = 4;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_LEN   = 3000;
  localparam int TAIL_CYCLES    = 200;
  localparam int RAND_PER_PHASE = 565;
  localparam int MAX_REPORTS    = 50;

  // Idling pattern the item was queued under
  typedef enum logic [1:0] {
    PH_RECV_SLOW,   // sender idles lightly, receiver heavily
    PH_SEND_SLOW,   // the other way round
    PH_FULL_RATE    // no random idling
  } idle_phase_e;

  typedef struct {
    logic        func;
    logic [6:0]  x1;
    logic [6:0]  y1;
    logic [6:0]  x2;
    logic [6:0]  y2;
    logic [31:0] delta;
    idle_phase_e phase;
  } fw_item_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [fw2d_pkg::IN_TW-1:0]  s_axis_tdata  = '0;
  logic                        s_axis_tuser  = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [fw2d_pkg::OUT_TW-1:0] m_axis_tdata;

  fw_item_t    pending_items[$];
  logic [31:0] expected_sums[$];
  logic [31:0] tree_copy[fw2d_pkg::DEPTH];
  fw_item_t    cur_item;
  idle_phase_e drv_phase     = PH_RECV_SLOW;
  int          err_cnt       = 0;
  int          quiet_cycles  = 0;
  int          hold_left     = 0;
  logic        hold_done     = 1'b0;

  fenwick_tree_2d_rect_sum i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tree copy
  // --------------------------------------------------------------------------

  // Sum over rows 1..r and columns 1..c, walking lowbit chains downward
  function automatic logic [31:0] prefix_total(int r, int c);
    logic [31:0] acc;
    int i, j;
    acc = '0;
    for (i = r; i > 0; i -= i & -i)
      for (j = c; j > 0; j -= j & -j)
        acc += tree_copy[(i - 1) * fw2d_pkg::COLS + (j - 1)];
    return acc;
  endfunction

  function automatic int clamp_row(int v);
    return (v > fw2d_pkg::ROWS) ? fw2d_pkg::ROWS : v;
  endfunction

  function automatic int clamp_col(int v);
    return (v > fw2d_pkg::COLS) ? fw2d_pkg::COLS : v;
  endfunction

  // Apply one accepted item to the tree copy; queries queue their sum
  function automatic void apply_to_tree(fw_item_t it);
    int r, c, rlo, clo, rhi, chi, i, j;
    logic [31:0] sum;
    r = it.x1;
    c = it.y1;
    if (it.func == fw2d_pkg::FUNC_ADD) begin
      // points off the grid leave the tree as it is
      if (r == 0 || r > fw2d_pkg::ROWS || c == 0 || c > fw2d_pkg::COLS) return;
      for (i = r; i <= fw2d_pkg::ROWS; i += i & -i)
        for (j = c; j <= fw2d_pkg::COLS; j += j & -j)
          tree_copy[(i - 1) * fw2d_pkg::COLS + (j - 1)] += it.delta;
    end else begin
      rhi = clamp_row(it.x2);
      chi = clamp_col(it.y2);
      rlo = (r == 0) ? 0 : clamp_row(r - 1);
      clo = (c == 0) ? 0 : clamp_col(c - 1);
      sum = prefix_total(rhi, chi) - prefix_total(rlo, chi)
          - prefix_total(rhi, clo) + prefix_total(rlo, clo);
      expected_sums = {expected_sums, sum};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int send_idle_pct(idle_phase_e ph);
    case (ph)
      PH_RECV_SLOW: return 32;
      PH_SEND_SLOW: return 87;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct(idle_phase_e ph);
    case (ph)
      PH_RECV_SLOW: return 87;
      PH_SEND_SLOW: return 32;
      default:      return 0;
    endcase
  endfunction

  task automatic queue_item(logic func, int x1, int y1, int x2, int y2,
                            logic [31:0] delta, idle_phase_e ph);
    fw_item_t it;
    it.func  = func;
    it.x1    = x1[6:0];
    it.y1    = y1[6:0];
    it.x2    = x2[6:0];
    it.y2    = y2[6:0];
    it.delta = delta;
    it.phase = ph;
    pending_items = {pending_items, it};
  endtask

  // Mostly on the grid, now and then anywhere in the 7-bit range
  function automatic int pick_coord();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 64);
    return $urandom_range(0, 127);
  endfunction

  function automatic logic [31:0] pick_delta();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(0, 2000) - 1000;
    if (sel < 8) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  task automatic queue_random(idle_phase_e ph);
    int a, b, c, d, t;
    a = pick_coord();
    b = pick_coord();
    c = pick_coord();
    d = pick_coord();
    // most rectangles are well ordered, the rest stay as drawn
    if ($urandom_range(0, 99) < 75) begin
      if (a > c) begin t = a; a = c; c = t; end
      if (b > d) begin t = b; b = d; d = t; end
    end
    queue_item($urandom_range(0, 1) ? fw2d_pkg::FUNC_QUERY : fw2d_pkg::FUNC_ADD,
               a, b, c, d, pick_delta(), ph);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: takes items from the pending queue, predicts on transfer
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : input_driver
    fw_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_to_tree(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct(pending_items[0].phase)) begin
          it = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(fw2d_pkg::IN_TW - fw2d_pkg::IN_BITS){1'b0}},
                            it.delta, it.y2, it.x2, it.y1, it.x1};
          s_axis_tuser  <= it.func;
          cur_item      <= it;
          drv_phase     <= it.phase;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side ready, with one long hold-off once full rate begins
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && drv_phase == PH_FULL_RATE) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_OFF_LEN;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct(drv_phase));
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_sums.size() == 0) begin
        err_cnt <= err_cnt + 1;
        if (err_cnt < MAX_REPORTS)
          $error("rect_sum: no sum expected, actual %0d", $signed(m_axis_tdata));
      end else begin
        want = expected_sums.pop_front();
        if (m_axis_tdata !== want) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < MAX_REPORTS)
            $error("rect_sum mismatch: expected %0d, actual %0d",
                   $signed(want), $signed(m_axis_tdata));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fenwick_tree_2d_rect_sum regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Item list, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int k;
    for (k = 0; k < fw2d_pkg::DEPTH; k++) tree_copy[k] = '0;

    // Directed: corners, extreme deltas, off-grid adds, odd rectangles
    queue_item(fw2d_pkg::FUNC_QUERY,   1,   1,  64,  64, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,     1,   1,   0,   0, 32'h7FFF_FFFF, PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,    64,  64,   0,   0, 32'h8000_0000, PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,     1,  64,   0,   0, 32'hFFFF_FFFF, PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,    64,   1,   0,   0, 32'd12345,     PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,     0,   5,   0,   0, 32'd100,       PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,    65,   5,   0,   0, 32'd100,       PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,     5,   0,   0,   0, 32'd100,       PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,     5, 127,   0,   0, 32'd100,       PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,   127, 127, 127, 127, 32'hFFFF_FFFF, PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,    32,  33, 127,   0, 32'h5555_5555, PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,   1,   1,  64,  64, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,   1,   1,   1,   1, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,  64,  64,  64,  64, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,   1,   1, 127, 127, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,   0,   1,  64,  64, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,   1,   0,  64,  64, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,   0,   0,   0,   0, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,  40,  40,  10,  10, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,  64,   1,   1,  64, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,   1,   1,   0,  64, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,  65,  65, 127, 127, 32'h0,         PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,  32,  33,  32,  33, 32'hFFFF_FFFF, PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_ADD,    64,  64,   0,   0, 32'h2AAA_AAAA, PH_RECV_SLOW);
    queue_item(fw2d_pkg::FUNC_QUERY,   1,   1,  64,  64, 32'h0,         PH_RECV_SLOW);

    // Random, one block per idling pattern
    for (k = 0; k < RAND_PER_PHASE; k++) queue_random(PH_RECV_SLOW);
    for (k = 0; k < RAND_PER_PHASE; k++) queue_random(PH_SEND_SLOW);
    for (k = 0; k < RAND_PER_PHASE; k++) queue_random(PH_FULL_RATE);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every item taken, every sum back, then let the block settle
    while (pending_items.size() != 0 || s_axis_tvalid || expected_sums.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("fenwick_tree_2d_rect_sum regression: pass");
    end else begin
      $display("fenwick_tree_2d_rect_sum regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
design/fw2d_pkg.sv
design/fw2d_dp.sv
design/fw2d_ctrl.sv
design/fenwick_tree_2d_rect_sum.sv
tb/sv/fenwick_tree_2d_rect_sum_tb.sv
